>>> rtl/gtrs_pkg.sv
// ----------------------------------------------------------------------------
// gtrs_pkg: shared types and constants for the giant tour route splitter
// Widths, cost constants and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package gtrs_pkg;

	localparam int MAX_CUSTOMERS = 31;
	localparam int IDX_W   = 5;
	localparam int CNT_W   = 6;
	localparam int ID_W    = 10;
	localparam int VAL_W   = 16;
	localparam int COST_W  = 32;
	localparam int LIM_W   = 19;  // multiplier * capacity
	localparam int NL_W    = 20;  // load plus one demand
	localparam int ROUTE_W = 21;  // up to MAX_CUSTOMERS arcs
	localparam int PROD_W  = 36;  // weight * overload + half
	localparam int SUM_W   = 34;

	localparam logic [COST_W-1:0] COST_INF = '1;

	// output item kinds
	localparam logic [1:0] OUT_ID  = 2'd0;
	localparam logic [1:0] OUT_DEP = 2'd1;
	localparam logic [1:0] OUT_INF = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_CAPACITY = 2'd0;
	localparam logic [1:0] REG_MULT     = 2'd1;
	localparam logic [1:0] REG_PENALTY  = 2'd2;

	typedef struct packed {
		logic [VAL_W-1:0] capacity;
		logic [2:0]       mult;
		logic [VAL_W-1:0] penalty;
	} cfg_t;

	typedef struct packed {
		logic             load_we;
		logic [IDX_W-1:0] load_addr;
		logic [IDX_W-1:0] cust_addr;
		logic [IDX_W-1:0] lab_addr;
		logic             init_we;
		logic             t_start;
		logic             latch_bt;
		logic             step_a;
		logic             first;
		logic             step_b;
		logic             step_c;
		logic [IDX_W-1:0] t_idx;
		logic             latch_total;
		logic             clr_end;
		logic             mark_end;
		logic [IDX_W-1:0] end_idx;
		logic             out_ld;
		logic [1:0]       out_kind;
		logic             out_last;
	} cmd_t;

	typedef struct packed {
		logic             brk;
		logic             lab_inf;
		logic [IDX_W-1:0] pred;
		logic             end_hit;
		logic             out_free;
	} stat_t;

endpackage

>>> rtl/gtrs_dp.sv
// ----------------------------------------------------------------------------
// gtrs_dp: datapath of the route splitter
// Customer stores, label memories, relaxation arithmetic, route-end marks
// and the output register.
// ----------------------------------------------------------------------------
module gtrs_dp import gtrs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  cmd_t              cmd,
	output stat_t             st,
	input  logic [79:0]       in_data,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [47:0]       m_tdata,
	output logic [1:0]        m_tuser,
	output logic              m_tlast
);

	logic [ID_W-1:0]   id_mem   [32];
	logic [VAL_W-1:0]  dem_mem  [32];
	logic [VAL_W-1:0]  out_mem  [32];
	logic [VAL_W-1:0]  back_mem [32];
	logic [VAL_W-1:0]  arc_mem  [32];
	logic [COST_W-1:0] best_mem [32];
	logic [IDX_W-1:0]  pred_mem [32];

	logic [ID_W-1:0]    id_rd_q;
	logic [VAL_W-1:0]   dem_rd_q, out_rd_q, back_rd_q, arc_rd_q;
	logic [COST_W-1:0]  best_rd_q;
	logic [IDX_W-1:0]   pred_rd_q;

	logic [COST_W-1:0]  bt_q, bestj_q, total_q;
	logic [LIM_W-1:0]   load_q, over_q;
	logic [ROUTE_W-1:0] route_q;
	logic [VAL_W-1:0]   back_q;
	logic [PROD_W-1:0]  prod_q;
	logic [31:0]        end_q;

	logic [ID_W-1:0]    node_q;
	logic [COST_W-1:0]  cost_q;
	logic               dep_q, inf_q, last_q, ovalid_q;

	logic [LIM_W-1:0]   limit;
	logic [NL_W-1:0]    nl;
	logic [SUM_W-1:0]   sum;
	logic [COST_W-1:0]  cand;
	logic               better;

	assign limit = LIM_W'(cfg.mult) * LIM_W'(cfg.capacity);
	assign nl    = NL_W'(load_q) + NL_W'(dem_rd_q);
	assign sum   = SUM_W'(bt_q) + SUM_W'(route_q) + SUM_W'(back_q)
		+ SUM_W'(prod_q[PROD_W-1:8]);
	assign cand  = (sum >= SUM_W'(COST_INF)) ? COST_INF : sum[COST_W-1:0];
	assign better = cand < bestj_q;

	assign st.brk      = nl > NL_W'(limit);
	assign st.lab_inf  = best_rd_q == COST_INF;
	assign st.pred     = pred_rd_q;
	assign st.end_hit  = end_q[cmd.end_idx];
	assign st.out_free = !ovalid_q || m_tready;

	// customer stores
	always_ff @(posedge clk) begin
		if (cmd.load_we) begin
			id_mem[cmd.load_addr]   <= in_data[9:0];
			dem_mem[cmd.load_addr]  <= in_data[25:10];
			out_mem[cmd.load_addr]  <= in_data[41:26];
			back_mem[cmd.load_addr] <= in_data[57:42];
			arc_mem[cmd.load_addr]  <= in_data[73:58];
		end
		id_rd_q   <= id_mem[cmd.cust_addr];
		dem_rd_q  <= dem_mem[cmd.cust_addr];
		out_rd_q  <= out_mem[cmd.cust_addr];
		back_rd_q <= back_mem[cmd.cust_addr];
		arc_rd_q  <= arc_mem[cmd.cust_addr];
	end

	// labels
	always_ff @(posedge clk) begin
		if (cmd.init_we) begin
			best_mem[cmd.lab_addr] <= (cmd.lab_addr == '0) ? '0 : COST_INF;
		end else if (cmd.step_c && better) begin
			best_mem[cmd.lab_addr] <= cand;
			pred_mem[cmd.lab_addr] <= cmd.t_idx;
		end
		best_rd_q <= best_mem[cmd.lab_addr];
		pred_rd_q <= pred_mem[cmd.lab_addr];
	end

	// relaxation step registers
	always_ff @(posedge clk) begin
		if (cmd.t_start) begin
			load_q  <= '0;
			route_q <= '0;
		end
		if (cmd.latch_bt)
			bt_q <= best_rd_q;
		if (cmd.latch_total)
			total_q <= best_rd_q;
		if (cmd.step_a && !st.brk) begin
			load_q  <= nl[LIM_W-1:0];
			route_q <= cmd.first ? ROUTE_W'(out_rd_q) : route_q + ROUTE_W'(arc_rd_q);
			over_q  <= (nl > NL_W'(cfg.capacity)) ?
				LIM_W'(nl - NL_W'(cfg.capacity)) : '0;
			back_q  <= back_rd_q;
			bestj_q <= best_rd_q;
		end
		if (cmd.step_b)
			prod_q <= PROD_W'(cfg.penalty) * PROD_W'(over_q) + PROD_W'(128);
	end

	// route-end marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_q <= '0;
		end else if (cmd.clr_end) begin
			end_q <= '0;
		end else if (cmd.mark_end) begin
			end_q[cmd.end_idx] <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			ovalid_q <= 1'b1;
		end else if (m_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			node_q <= (cmd.out_kind == OUT_ID) ? id_rd_q : '0;
			dep_q  <= cmd.out_kind != OUT_ID;
			inf_q  <= cmd.out_kind == OUT_INF;
			last_q <= cmd.out_last;
			cost_q <= cmd.out_last ? total_q : '0;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {6'd0, cost_q, node_q};
	assign m_tuser  = {inf_q, dep_q};
	assign m_tlast  = last_q;

endmodule

>>> rtl/gtrs_ctrl.sv
// ----------------------------------------------------------------------------
// gtrs_ctrl: controller of the route splitter
// Sequences load, label init, relaxation, backtrack and emit.
// ----------------------------------------------------------------------------
module gtrs_ctrl import gtrs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	input  logic  s_tlast,
	input  stat_t st,
	output cmd_t  cmd
);

	localparam logic [3:0] S_LOAD    = 4'd0;
	localparam logic [3:0] S_INIT    = 4'd1;
	localparam logic [3:0] S_T_RD    = 4'd2;
	localparam logic [3:0] S_T_CHK   = 4'd3;
	localparam logic [3:0] S_J_RD    = 4'd4;
	localparam logic [3:0] S_J_A     = 4'd5;
	localparam logic [3:0] S_J_B     = 4'd6;
	localparam logic [3:0] S_J_C     = 4'd7;
	localparam logic [3:0] S_TOT_RD  = 4'd8;
	localparam logic [3:0] S_TOT_CHK = 4'd9;
	localparam logic [3:0] S_BT_RD   = 4'd10;
	localparam logic [3:0] S_BT_CHK  = 4'd11;
	localparam logic [3:0] S_E_DEP0  = 4'd12;
	localparam logic [3:0] S_E_RD    = 4'd13;
	localparam logic [3:0] S_E_ID    = 4'd14;
	localparam logic [3:0] S_E_DEP   = 4'd15;

	logic [3:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [IDX_W-1:0] n_q, n_d, t_q, t_d, j_q, j_d, p_q, p_d, cur_q, cur_d;
	logic             inf_q, inf_d;
	logic             room;
	logic [IDX_W-1:0] nc;

	assign s_tready = state_q == S_LOAD;
	assign room     = cnt_q < CNT_W'(MAX_CUSTOMERS);
	assign nc       = (st.pred >= cur_q) ? '0 : st.pred;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		cnt_d     = cnt_q;
		n_d       = n_q;
		t_d       = t_q;
		j_d       = j_q;
		p_d       = p_q;
		cur_d     = cur_q;
		inf_d     = inf_q;
		cmd.load_addr = cnt_q[IDX_W-1:0] + IDX_W'(1);
		cmd.t_idx     = t_q;
		cmd.end_idx   = p_q;
		unique case (state_q)
			S_LOAD: begin
				if (s_tvalid) begin
					cmd.load_we = room;
					if (room)
						cnt_d = cnt_q + CNT_W'(1);
					if (s_tlast) begin
						n_d     = room ? cnt_q[IDX_W-1:0] + IDX_W'(1) : cnt_q[IDX_W-1:0];
						cnt_d   = '0;
						j_d     = '0;
						state_d = S_INIT;
					end
				end
			end
			S_INIT: begin
				cmd.init_we  = 1'b1;
				cmd.clr_end  = 1'b1;
				cmd.lab_addr = j_q;
				if (j_q == n_q) begin
					t_d     = '0;
					state_d = S_T_RD;
				end else begin
					j_d = j_q + IDX_W'(1);
				end
			end
			S_T_RD: begin
				cmd.lab_addr = t_q;
				cmd.t_start  = 1'b1;
				state_d      = S_T_CHK;
			end
			S_T_CHK: begin
				cmd.latch_bt = 1'b1;
				if (st.lab_inf) begin
					if (t_q + IDX_W'(1) == n_q) begin
						state_d = S_TOT_RD;
					end else begin
						t_d     = t_q + IDX_W'(1);
						state_d = S_T_RD;
					end
				end else begin
					j_d     = t_q + IDX_W'(1);
					state_d = S_J_RD;
				end
			end
			S_J_RD: begin
				cmd.cust_addr = j_q;
				cmd.lab_addr  = j_q;
				state_d       = S_J_A;
			end
			S_J_A: begin
				cmd.step_a = 1'b1;
				cmd.first  = j_q == t_q + IDX_W'(1);
				if (st.brk) begin
					if (t_q + IDX_W'(1) == n_q) begin
						state_d = S_TOT_RD;
					end else begin
						t_d     = t_q + IDX_W'(1);
						state_d = S_T_RD;
					end
				end else begin
					state_d = S_J_B;
				end
			end
			S_J_B: begin
				cmd.step_b = 1'b1;
				state_d    = S_J_C;
			end
			S_J_C: begin
				cmd.step_c   = 1'b1;
				cmd.lab_addr = j_q;
				if (j_q == n_q) begin
					if (t_q + IDX_W'(1) == n_q) begin
						state_d = S_TOT_RD;
					end else begin
						t_d     = t_q + IDX_W'(1);
						state_d = S_T_RD;
					end
				end else begin
					j_d     = j_q + IDX_W'(1);
					state_d = S_J_RD;
				end
			end
			S_TOT_RD: begin
				cmd.lab_addr = n_q;
				state_d      = S_TOT_CHK;
			end
			S_TOT_CHK: begin
				cmd.latch_total = 1'b1;
				inf_d           = st.lab_inf;
				cur_d           = n_q;
				state_d         = st.lab_inf ? S_E_DEP0 : S_BT_RD;
			end
			S_BT_RD: begin
				cmd.lab_addr = cur_q;
				cmd.mark_end = 1'b1;
				cmd.end_idx  = cur_q;
				state_d      = S_BT_CHK;
			end
			S_BT_CHK: begin
				if (nc == '0) begin
					state_d = S_E_DEP0;
				end else begin
					cur_d   = nc;
					state_d = S_BT_RD;
				end
			end
			S_E_DEP0: begin
				if (st.out_free) begin
					cmd.out_ld   = 1'b1;
					cmd.out_kind = inf_q ? OUT_INF : OUT_DEP;
					cmd.out_last = inf_q;
					p_d          = IDX_W'(1);
					state_d      = inf_q ? S_LOAD : S_E_RD;
				end
			end
			S_E_RD: begin
				cmd.cust_addr = p_q;
				state_d       = S_E_ID;
			end
			S_E_ID: begin
				// keep the read address so the id survives an output stall
				cmd.cust_addr = p_q;
				if (st.out_free) begin
					cmd.out_ld   = 1'b1;
					cmd.out_kind = OUT_ID;
					if (st.end_hit) begin
						state_d = S_E_DEP;
					end else begin
						p_d     = p_q + IDX_W'(1);
						state_d = S_E_RD;
					end
				end
			end
			S_E_DEP: begin
				if (st.out_free) begin
					cmd.out_ld   = 1'b1;
					cmd.out_kind = OUT_DEP;
					cmd.out_last = p_q == n_q;
					if (p_q == n_q) begin
						state_d = S_LOAD;
					end else begin
						p_d     = p_q + IDX_W'(1);
						state_d = S_E_RD;
					end
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q   <= '0;
			n_q     <= '0;
			t_q     <= '0;
			j_q     <= '0;
			p_q     <= '0;
			cur_q   <= '0;
			inf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			n_q     <= n_d;
			t_q     <= t_d;
			j_q     <= j_d;
			p_q     <= p_d;
			cur_q   <= cur_d;
			inf_q   <= inf_d;
		end
	end

endmodule

>>> rtl/giant_tour_route_split.sv
// ----------------------------------------------------------------------------
// giant_tour_route_split: split a giant tour into capacity-bounded routes
// Shortest-path split over a loaded customer sequence, emitted as a
// depot-separated route list with the total cost.
// ----------------------------------------------------------------------------
// The tour is loaded one customer per transfer (one cycle each, up to 31
// customers; extra ones are dropped). The transfer with tlast closes the tour
// and the block stops taking input until the whole route list has gone out.
// Compute time is set by the relaxation loop, which shares one adder/multiplier
// datapath and one label memory port: label init, then a label read and check
// per start position and the states J_RD, J_A, J_B and J_C per route extension,
// then a backtrack per route and an emit of each customer and each depot mark.
// Costs saturate at all ones, which also means unreachable; if no split
// exists a single depot item goes out with the infeasible flag and that cost.
// Configuration writes are taken at any time on cfg_* but must only be made
// while the block is idle.
module giant_tour_route_split import gtrs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// customer_id[9:0], demand[25:10], dist_from_depot[41:26],
	// dist_to_depot[57:42], dist_from_prev[73:58], zero pad[79:74]
	input  logic [79:0] s_tdata,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// node_id[9:0], total_cost[41:10], zero pad[47:42]
	output logic [47:0] m_tdata,
	// is_depot[0], infeasible[1]
	output logic [1:0]  m_tuser,
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t  cfg_q;
	cmd_t  cmd;
	stat_t st;

	assign cfg_ready = 1'b1;

	// configuration registers; an index past the list is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.capacity <= VAL_W'(100);
			cfg_q.mult     <= 3'd1;
			cfg_q.penalty  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CAPACITY: cfg_q.capacity <= cfg_data;
				REG_MULT:     cfg_q.mult     <= cfg_data[2:0];
				REG_PENALTY:  cfg_q.penalty  <= cfg_data;
				default: ;
			endcase
		end
	end

	gtrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tlast  (s_tlast),
		.st       (st),
		.cmd      (cmd)
	);

	gtrs_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd      (cmd),
		.st       (st),
		.in_data  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

>>> tb/sv/tb_giant_tour_route_split.sv
// ----------------------------------------------------------------------------
// tb_giant_tour_route_split: self-checking bench for the giant tour splitter
// Loads tours over the input stream, predicts the split route list and total
// cost in a local model, and compares every output transfer in order.
// ----------------------------------------------------------------------------
module tb_giant_tour_route_split;
	import gtrs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [ID_W-1:0]   node;
		logic              depot;
		logic [COST_W-1:0] cost;
		logic              infeas;
		logic              fin;
	} route_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	giant_tour_route_split u_dut (.*);

	always #2 clk = ~clk;

	// shadow configuration and tour store
	logic [15:0] sh_cap = 16'd100;
	logic [2:0]  sh_mult = 3'd1;
	logic [15:0] sh_pen = 16'd0;
	logic [ID_W-1:0] tour_id [32];
	logic [15:0] tour_dem [32], tour_out [32], tour_back [32], tour_arc [32];
	int unsigned tour_len = 0;

	route_item_t routes_pending[$];
	int errors = 0;
	int send_idle = 0;    // percent
	int recv_idle = 0;    // percent
	int hold_cycles = 0;  // long receiver hold-off

	// Shortest-path split of the stored tour; queues the expected route list.
	task automatic predict_split();
		logic [31:0] label [32];
		logic [4:0]  pred [32];
		logic [63:0] lim, load, route, over, pen, sum;
		logic [10:0] seq [64];
		int len, cur, t, j, n;
		route_item_t r;
		n = tour_len;
		tour_len = 0;
		lim = 64'(sh_mult) * 64'(sh_cap);
		label[0] = 0;
		pred[0] = 0;
		for (j = 1; j <= n; j++) begin
			label[j] = COST_INF;
			pred[j] = 0;
		end
		for (t = 0; t < n; t++) begin
			if (label[t] == COST_INF) continue;
			load = 0;
			route = 0;
			for (j = t + 1; j <= n; j++) begin
				if (load + tour_dem[j] > lim) break;
				load += tour_dem[j];
				route += (j == t + 1) ? tour_out[j] : tour_arc[j];
				over = (load > sh_cap) ? load - sh_cap : 0;
				pen = (64'(sh_pen) * over + 128) >> 8;
				sum = 64'(label[t]) + route + tour_back[j] + pen;
				if (sum >= 64'(COST_INF)) sum = 64'(COST_INF);
				if (sum[31:0] < label[j]) begin
					label[j] = sum[31:0];
					pred[j] = 5'(t);
				end
			end
		end
		if (label[n] == COST_INF) begin
			r = '{node: '0, depot: 1'b1, cost: COST_INF, infeas: 1'b1, fin: 1'b1};
			routes_pending = {routes_pending, r};
			return;
		end
		len = 0;
		seq[len] = 11'h400;
		len++;
		cur = n;
		while (cur > 0) begin
			t = pred[cur];
			if (t >= cur) t = 0;
			for (j = cur; j > t; j--) begin
				seq[len] = {1'b0, tour_id[j]};
				len++;
			end
			seq[len] = 11'h400;
			len++;
			cur = t;
		end
		for (j = 0; j < len; j++) begin
			r.depot = seq[len-1-j][10];
			r.node = r.depot ? '0 : seq[len-1-j][9:0];
			r.fin = (j == len - 1);
			r.cost = r.fin ? label[n] : '0;
			r.infeas = 1'b0;
			routes_pending = {routes_pending, r};
		end
	endtask

	// One customer transfer on the input stream.
	task automatic send_customer(input logic [9:0] id, input logic [15:0] dem,
			input logic [15:0] d_out, input logic [15:0] d_back,
			input logic [15:0] d_prev, input logic lst);
		while ($urandom_range(99) < send_idle) @(negedge clk);
		s_tvalid = 1'b1;
		s_tdata <= {6'd0, d_prev, d_back, d_out, dem, id};
		s_tlast <= lst;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		// store only while there is room; overflow items are dropped
		if (tour_len < MAX_CUSTOMERS) begin
			tour_len++;
			tour_id[tour_len] = id;
			tour_dem[tour_len] = dem;
			tour_out[tour_len] = d_out;
			tour_back[tour_len] = d_back;
			tour_arc[tour_len] = d_prev;
		end
		if (lst) predict_split();
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic wait_drained();
		while (routes_pending.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid = 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_CAPACITY: sh_cap = val;
			REG_MULT:     sh_mult = val[2:0];
			default:      sh_pen = val;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_config(input logic [15:0] cap, input logic [15:0] mult,
			input logic [15:0] pen);
		wait_drained();
		write_reg(REG_CAPACITY, cap);
		write_reg(REG_MULT, mult);
		write_reg(REG_PENALTY, pen);
	endtask

	// Random tour; demands scaled near capacity so splits are non-trivial.
	task automatic send_random_tour(input int n, input int dem_max);
		for (int i = 1; i <= n; i++)
			send_customer(10'($urandom_range(1023, 1)), 16'($urandom_range(dem_max)),
				16'($urandom), 16'($urandom), 16'($urandom), i == n);
	endtask

	// Directed: field extremes, zero id, first-position arc, single route.
	task automatic test_directed();
		set_config(16'd100, 16'd1, 16'd0);
		send_customer(10'd1, 16'd0, 16'd0, 16'd0, 16'hFFFF, 1'b1);
		send_customer(10'd1023, 16'd50, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		send_customer(10'd0, 16'd50, 16'd1, 16'd1, 16'd0, 1'b0);
		send_customer(10'h2AA, 16'd60, 16'h5555, 16'hAAAA, 16'h1234, 1'b1);
		// demand too large: no split
		send_customer(10'h155, 16'hFFFF, 16'd3, 16'd3, 16'd3, 1'b1);
		// overload penalty, multiplier extremes
		set_config(16'd10, 16'd4, 16'hFFFF);
		send_customer(10'd5, 16'd25, 16'd7, 16'd9, 16'd0, 1'b0);
		send_customer(10'd6, 16'd15, 16'd1, 16'd1, 16'd2, 1'b1);
		set_config(16'hFFFF, 16'd7, 16'h0180);
		send_customer(10'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 1'b0);
		send_customer(10'd8, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		// multiplier zero admits only zero-demand customers
		set_config(16'd1, 16'd0, 16'd0);
		send_customer(10'd9, 16'd0, 16'd4, 16'd4, 16'd4, 1'b0);
		send_customer(10'd10, 16'd1, 16'd4, 16'd4, 16'd4, 1'b1);
	endtask

	// Tour overflow: 34 items, the last three dropped, last still starts compute.
	task automatic test_overflow();
		set_config(16'd300, 16'd2, 16'd128);
		send_random_tour(34, 150);
	endtask

	task automatic test_random(input int items);
		int sent = 0, n;
		while (sent < items) begin
			if ($urandom_range(3) == 0)
				set_config(16'($urandom_range(65535, 1)), 16'($urandom_range(4, 1)),
					16'($urandom));
			else
				set_config(16'($urandom_range(400, 1)), 16'($urandom_range(4, 1)),
					16'($urandom_range(1024)));
			n = ($urandom_range(4) == 0) ? $urandom_range(31, 16) : $urandom_range(8, 1);
			send_random_tour(n, $urandom_range(3) == 0 ? 65535 : 2 * sh_cap);
			sent += n;
		end
	endtask

	// Receiver: random stalls, optional long hold-off counted here.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Result checker, sampled at the rising edge.
	always @(posedge clk) begin
		route_item_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (routes_pending.size() == 0) begin
				$display("%0t: unexpected transfer node=%0d", $realtime, m_tdata[9:0]);
				errors++;
			end else begin
				e = routes_pending.pop_front();
				if (m_tdata[9:0] !== e.node) begin
					$display("%0t: node_id exp %0d got %0d", $realtime, e.node, m_tdata[9:0]);
					errors++;
				end
				if (m_tuser[0] !== e.depot) begin
					$display("%0t: is_depot exp %0d got %0d", $realtime, e.depot, m_tuser[0]);
					errors++;
				end
				if (m_tdata[41:10] !== e.cost) begin
					$display("%0t: total_cost exp %0h got %0h", $realtime, e.cost,
						m_tdata[41:10]);
					errors++;
				end
				if (m_tuser[1] !== e.infeas) begin
					$display("%0t: infeasible exp %0d got %0d", $realtime, e.infeas,
						m_tuser[1]);
					errors++;
				end
				if (m_tlast !== e.fin) begin
					$display("%0t: last exp %0d got %0d", $realtime, e.fin, m_tlast);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_idle = 8;
		recv_idle = 69;
		test_directed();
		test_overflow();
		test_random(50);
		send_idle = 69;
		recv_idle = 8;
		test_random(40);
		send_idle = 0;
		recv_idle = 0;
		// long hold-off while tours keep coming, so input backs up
		hold_cycles = 3000;
		send_random_tour(6, 150);
		send_random_tour(5, 150);
		test_random(40);
		wait_drained();
		repeat (100) @(negedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#4ms;
		$display("CHECK FAILED");
		$finish;
	end
endmodule
